[hw/rtl/c8_pkg.sv]
// Shared constants, types and the font table of the CHIP-8 core.
package c8_pkg;

   localparam int MemAddrWidth = 12;
   localparam int MemBytes = 4096;
   localparam int DefStackDepth = 16;
   localparam int ScreenWidth = 64;
   localparam int ScreenHeight = 32;
   localparam int RowWidth = 5;

   localparam logic [11:0] PROG_START = 12'h200;
   localparam logic [11:0] FONT_BASE = 12'h050;
   localparam logic [11:0] FONT_END = 12'h0A0;
   localparam logic [11:0] ADDR_LAST = 12'hFFF;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_EXEC = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;
   localparam logic [1:0] MODE_ROW = 2'd3;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   localparam logic [3:0] GRP_JUMP = 4'h1;
   localparam logic [3:0] GRP_CALL = 4'h2;
   localparam logic [3:0] GRP_SEQ_K = 4'h3;
   localparam logic [3:0] GRP_SNE_K = 4'h4;
   localparam logic [3:0] GRP_SEQ_R = 4'h5;
   localparam logic [3:0] GRP_LOAD_K = 4'h6;
   localparam logic [3:0] GRP_ADD_K = 4'h7;
   localparam logic [3:0] GRP_ALU = 4'h8;
   localparam logic [3:0] GRP_SNE_R = 4'h9;
   localparam logic [3:0] GRP_SET_I = 4'hA;
   localparam logic [3:0] GRP_JUMP_OFS = 4'hB;
   localparam logic [3:0] GRP_RAND = 4'hC;
   localparam logic [3:0] GRP_DRAW = 4'hD;
   localparam logic [3:0] GRP_KEY = 4'hE;
   localparam logic [3:0] GRP_MISC = 4'hF;

   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   localparam logic [7:0] KEY_DOWN = 8'h9E;
   localparam logic [7:0] KEY_UP = 8'hA1;
   localparam logic [7:0] MISC_GET_DELAY = 8'h07;
   localparam logic [7:0] MISC_WAIT_KEY = 8'h0A;
   localparam logic [7:0] MISC_SET_DELAY = 8'h15;
   localparam logic [7:0] MISC_SET_SOUND = 8'h18;
   localparam logic [7:0] MISC_ADD_I = 8'h1E;
   localparam logic [7:0] MISC_FONT = 8'h29;
   localparam logic [7:0] MISC_BCD = 8'h33;
   localparam logic [7:0] MISC_STORE = 8'h55;
   localparam logic [7:0] MISC_LOAD = 8'h65;

   localparam logic [1:0] CSR_LOGIC_CLEAR = 2'd0;
   localparam logic [1:0] CSR_SHIFT_VY = 2'd1;
   localparam logic [1:0] CSR_BULK_ADV = 2'd2;
   localparam logic [1:0] CSR_JUMP_VX = 2'd3;

   typedef enum logic [4:0] {
      CMD_CLEAR, CMD_ACCEPT, CMD_DISPATCH, CMD_WRITE, CMD_TICK, CMD_ROW,
      CMD_FETCH_HI, CMD_FETCH_LO, CMD_READ_X, CMD_READ_Y, CMD_EXEC,
      CMD_WRITE_F, CMD_POP, CMD_DRAW_RD, CMD_DRAW_WR, CMD_BCD,
      CMD_STORE_RD, CMD_STORE_WR, CMD_LOAD_RD, CMD_LOAD_WR, CMD_ADV_INDEX,
      CMD_FINISH
   } cmd_op_type;

   typedef enum logic [2:0] {
      KIND_SIMPLE, KIND_FLAG, KIND_POP, KIND_DRAW, KIND_BCD, KIND_STORE, KIND_LOAD
   } kind_type;

   typedef struct packed {
      cmd_op_type op;
   } cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic       req_valid;
      logic [1:0] mode;
      logic       halted;
      kind_type   kind;
      logic       loop_done;
      logic       rsp_free;
   } status_type;

   localparam logic [7:0] HEX_GLYPHS [80] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   // Power-on content of one memory byte: the font, zero elsewhere.
   function automatic logic [7:0] boot_byte(input logic [11:0] addr);
      logic [11:0] ofs;
      begin
         ofs = addr - FONT_BASE;
         if (addr >= FONT_BASE && addr < FONT_END) begin
            boot_byte = HEX_GLYPHS[ofs[6:0]];
         end else begin
            boot_byte = 8'h00;
         end
      end
   endfunction

endpackage

[hw/rtl/c8_if.sv]
// Request and response channel interfaces of the CHIP-8 core.
interface c8_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [11:0] address;
   logic [7:0]  write_byte;
   logic [15:0] key_states;
   logic [7:0]  random_byte;

   modport source (output valid, mode, address, write_byte, key_states, random_byte,
                   input ready);
   modport sink (input valid, mode, address, write_byte, key_states, random_byte,
                 output ready);
endinterface

interface c8_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] display_row;
   logic [11:0] program_counter;
   logic        halted;
   logic        sound_active;
   logic        redraw_needed;

   modport source (output valid, display_row, program_counter, halted, sound_active,
                   redraw_needed, input ready);
   modport sink (input valid, display_row, program_counter, halted, sound_active,
                 redraw_needed, output ready);
endinterface

[hw/rtl/chip8_cpu_core.sv]
// Top level of the CHIP-8 core: sequencer, datapath and channel wiring.
//
// Requests arrive on the req channel, one beat per operation: write a program
// byte, execute one instruction, apply one 60 Hz timer tick, or read a display
// row. Each request yields exactly one beat on the rsp channel carrying the row
// (read only), the program counter, the halt and sound flags and, for a tick,
// whether the display changed since the previous tick.
// Four quirk flags are written through the csr port; the user must write them
// only while the core is idle, as the block does not enforce it. One request
// is processed at a time. A byte write, tick or row read goes through its own
// state to the finish state, which loads the result register. An instruction
// is fetched, reads its registers, executes and may then write the flag
// register or pop the stack; a sprite reads and writes back each drawn row, a
// register store or load each register, and the decimal conversion writes
// three digits. After reset a clearing pass over all 4096 bytes loads the font
// at 0x50 and zeroes the rest of memory and the registers; no request is
// accepted meanwhile, so the program must be written again afterwards. The
// result register frees the datapath, so a new request is taken while a
// result beat still waits for the receiver; if that beat is still stalled when
// the next result is due, the sequencer holds until the receiver takes it.
module chip8_cpu_core #(
   parameter int STACK_DEPTH = c8_pkg::DefStackDepth
) (
   input  logic          clock,
   input  logic          reset,
   c8_req_if.sink        req,
   c8_rsp_if.source      rsp,
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic          csr_write_data
);
   import c8_pkg::*;

   cmd_type    cmd;
   status_type status;

   c8_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   c8_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_valid           (req.valid),
      .req_ready           (req.ready),
      .req_mode            (req.mode),
      .req_address         (req.address),
      .req_write_byte      (req.write_byte),
      .req_key_states      (req.key_states),
      .req_random_byte     (req.random_byte),
      .rsp_valid           (rsp.valid),
      .rsp_ready           (rsp.ready),
      .rsp_display_row     (rsp.display_row),
      .rsp_program_counter (rsp.program_counter),
      .rsp_halted          (rsp.halted),
      .rsp_sound_active    (rsp.sound_active),
      .rsp_redraw_needed   (rsp.redraw_needed),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // No request is taken while memory is being initialised.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CMD_CLEAR) |-> !req.ready)
      else $error("request ready during the clearing pass");

   // Once a request beat is taken, the core is busy on the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request ready directly after an accepted beat");

   // Only reset releases a halted core.
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      status.halted |=> status.halted)
      else $error("halt flag cleared without reset");

endmodule

[hw/rtl/c8_ctrl.sv]
// Sequencer state machine of the CHIP-8 core.
module c8_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  c8_pkg::status_type  status,
   output c8_pkg::cmd_type     cmd
);
   import c8_pkg::*;

   typedef enum logic [21:0] {
      ST_CLEAR    = 22'h000001,
      ST_IDLE     = 22'h000002,
      ST_DISPATCH = 22'h000004,
      ST_WRITE    = 22'h000008,
      ST_TICK     = 22'h000010,
      ST_ROW      = 22'h000020,
      ST_FETCH_HI = 22'h000040,
      ST_FETCH_LO = 22'h000080,
      ST_READ_X   = 22'h000100,
      ST_READ_Y   = 22'h000200,
      ST_EXEC     = 22'h000400,
      ST_WRITE_F  = 22'h000800,
      ST_POP      = 22'h001000,
      ST_DRAW_RD  = 22'h002000,
      ST_DRAW_WR  = 22'h004000,
      ST_BCD      = 22'h008000,
      ST_STORE_RD = 22'h010000,
      ST_STORE_WR = 22'h020000,
      ST_LOAD_RD  = 22'h040000,
      ST_LOAD_WR  = 22'h080000,
      ST_ADV      = 22'h100000,
      ST_FINISH   = 22'h200000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op = CMD_FINISH;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = CMD_CLEAR;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.op = CMD_ACCEPT;
            if (status.req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            cmd.op = CMD_DISPATCH;
            unique case (status.mode)
               MODE_WRITE: state_in = ST_WRITE;
               MODE_EXEC:  state_in = status.halted ? ST_FINISH : ST_FETCH_HI;
               MODE_TICK:  state_in = ST_TICK;
               default:    state_in = ST_ROW;
            endcase
         end
         ST_WRITE: begin
            cmd.op = CMD_WRITE;
            state_in = ST_FINISH;
         end
         ST_TICK: begin
            cmd.op = CMD_TICK;
            state_in = ST_FINISH;
         end
         ST_ROW: begin
            cmd.op = CMD_ROW;
            state_in = ST_FINISH;
         end
         ST_FETCH_HI: begin
            cmd.op = CMD_FETCH_HI;
            state_in = ST_FETCH_LO;
         end
         ST_FETCH_LO: begin
            cmd.op = CMD_FETCH_LO;
            state_in = ST_READ_X;
         end
         ST_READ_X: begin
            cmd.op = CMD_READ_X;
            state_in = ST_READ_Y;
         end
         ST_READ_Y: begin
            cmd.op = CMD_READ_Y;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.op = CMD_EXEC;
            unique case (status.kind)
               KIND_FLAG:  state_in = ST_WRITE_F;
               KIND_POP:   state_in = ST_POP;
               KIND_DRAW:  state_in = ST_DRAW_RD;
               KIND_BCD:   state_in = ST_BCD;
               KIND_STORE: state_in = ST_STORE_RD;
               KIND_LOAD:  state_in = ST_LOAD_RD;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_WRITE_F: begin
            cmd.op = CMD_WRITE_F;
            state_in = ST_FINISH;
         end
         ST_POP: begin
            cmd.op = CMD_POP;
            state_in = ST_FINISH;
         end
         ST_DRAW_RD: begin
            cmd.op = CMD_DRAW_RD;
            state_in = status.loop_done ? ST_WRITE_F : ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            cmd.op = CMD_DRAW_WR;
            state_in = ST_DRAW_RD;
         end
         ST_BCD: begin
            cmd.op = CMD_BCD;
            if (status.loop_done) state_in = ST_FINISH;
         end
         ST_STORE_RD: begin
            cmd.op = CMD_STORE_RD;
            state_in = ST_STORE_WR;
         end
         ST_STORE_WR: begin
            cmd.op = CMD_STORE_WR;
            state_in = status.loop_done ? ST_ADV : ST_STORE_RD;
         end
         ST_LOAD_RD: begin
            cmd.op = CMD_LOAD_RD;
            state_in = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            cmd.op = CMD_LOAD_WR;
            state_in = status.loop_done ? ST_ADV : ST_LOAD_RD;
         end
         ST_ADV: begin
            cmd.op = CMD_ADV_INDEX;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.op = CMD_FINISH;
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            cmd.op = CMD_FINISH;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/c8_datapath.sv]
// Datapath of the CHIP-8 core: memories, registers, display and result stage.
module c8_datapath #(
   parameter int STACK_DEPTH = c8_pkg::DefStackDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  c8_pkg::cmd_type    cmd,
   output c8_pkg::status_type status,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [11:0]        req_address,
   input  logic [7:0]         req_write_byte,
   input  logic [15:0]        req_key_states,
   input  logic [7:0]         req_random_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_display_row,
   output logic [11:0]        rsp_program_counter,
   output logic               rsp_halted,
   output logic               rsp_sound_active,
   output logic               rsp_redraw_needed,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic               csr_write_data
);
   import c8_pkg::*;

   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DW = $clog2(STACK_DEPTH + 1);

   // Request fields.
   logic [1:0]  mode_ff;
   logic [11:0] addr_ff;
   logic [7:0]  wbyte_ff;
   logic [15:0] keys_ff;
   logic [7:0]  rnd_ff;

   // Architectural state.
   logic [11:0] pc_ff, index_ff;
   logic [DW-1:0] depth_ff;
   logic [7:0]  delay_ff, sound_ff;
   logic [4:0]  latch_ff;
   logic        halt_ff, draw_ff;
   logic [ScreenWidth-1:0] fb_ff [ScreenHeight];
   logic        cfg_logic_clear_ff, cfg_shift_vy_ff, cfg_bulk_adv_ff, cfg_jump_vx_ff;

   // Working registers.
   logic [15:0] op_ff;
   logic [7:0]  vx_ff, vy_ff, f_ff;
   logic [4:0]  cnt_ff;
   logic [11:0] clr_ff;
   logic [63:0] row_ff;
   logic        redraw_ff;

   // Memories.
   logic [7:0]  mem_ff [MemBytes];
   logic [7:0]  mem_rd_ff;
   logic [7:0]  regs_ff [16];
   logic [7:0]  reg_rd_ff;
   logic [11:0] stack_ff [STACK_DEPTH];
   logic [11:0] stack_rd_ff;

   // Result stage.
   logic        rsp_valid_ff;
   logic [63:0] rsp_row_ff;
   logic [11:0] rsp_pc_ff;
   logic        rsp_halt_ff, rsp_sound_ff, rsp_redraw_ff;

   logic [3:0]  op_grp, op_x, op_y, op_n;
   logic [7:0]  op_kk;
   logic [11:0] op_nnn;
   logic [7:0]  vy;
   logic [11:0] walk_addr;

   logic        mem_we;
   logic [11:0] mem_waddr, mem_raddr;
   logic [7:0]  mem_wdata;
   logic        reg_we;
   logic [3:0]  reg_waddr, reg_raddr;
   logic [7:0]  reg_wdata;
   logic        stack_we;
   logic [SW-1:0] stack_addr;

   logic        alu_we, skip;
   logic [7:0]  alu_val, alu_f, shift_src;
   logic [8:0]  sum9;
   logic [3:0]  first_key;
   logic        any_key;
   logic [5:0]  draw_py;
   logic [63:0] draw_mask;
   logic [1:0]  bcd_h;
   logic [7:0]  bcd_rem;
   logic [14:0] bcd_prod;
   logic [3:0]  bcd_t;
   logic [7:0]  bcd_o, bcd_digit;
   kind_type    kind;
   logic        loop_done;
   logic        rsp_free;

   assign op_grp = op_ff[15:12];
   assign op_x = op_ff[11:8];
   assign op_y = op_ff[7:4];
   assign op_n = op_ff[3:0];
   assign op_kk = op_ff[7:0];
   assign op_nnn = op_ff[11:0];
   assign vy = reg_rd_ff;
   assign walk_addr = index_ff + {7'd0, cnt_ff};

   // Lowest held key.
   always_comb begin
      first_key = 4'd0;
      any_key = 1'b0;
      for (int k = 15; k >= 0; k--) begin
         if (keys_ff[k]) begin
            first_key = 4'(k);
            any_key = 1'b1;
         end
      end
   end

   assign draw_py = {1'b0, vy_ff[4:0]} + {1'b0, cnt_ff};
   assign draw_mask = {mem_rd_ff, 56'd0} >> vx_ff[5:0];

   // Decimal digits of Vx: hundreds by compare, tens by reciprocal multiply.
   always_comb begin
      if (vx_ff >= 8'd200) bcd_h = 2'd2;
      else if (vx_ff >= 8'd100) bcd_h = 2'd1;
      else bcd_h = 2'd0;
      bcd_rem = vx_ff - 8'({bcd_h, 6'd0} + {bcd_h, 5'd0} + {bcd_h, 2'd0});
      bcd_prod = {8'd0, bcd_rem[6:0]} * 15'd205;
      bcd_t = bcd_prod[14:11];
      bcd_o = bcd_rem - {bcd_t, 3'd0} - {3'd0, bcd_t, 1'b0};
      case (cnt_ff[1:0])
         2'd0:    bcd_digit = {6'd0, bcd_h};
         2'd1:    bcd_digit = {4'd0, bcd_t};
         default: bcd_digit = bcd_o;
      endcase
   end

   // Register results of one instruction.
   always_comb begin
      alu_we = 1'b0;
      alu_val = 8'd0;
      alu_f = 8'd0;
      sum9 = {1'b0, vx_ff} + {1'b0, vy};
      shift_src = cfg_shift_vy_ff ? vy : vx_ff;
      unique case (op_grp)
         GRP_LOAD_K: begin alu_we = 1'b1; alu_val = op_kk; end
         GRP_ADD_K:  begin alu_we = 1'b1; alu_val = vx_ff + op_kk; end
         GRP_RAND:   begin alu_we = 1'b1; alu_val = rnd_ff & op_kk; end
         GRP_ALU: begin
            alu_we = 1'b1;
            case (op_n)
               ALU_MOV:  alu_val = vy;
               ALU_OR:   alu_val = vx_ff | vy;
               ALU_AND:  alu_val = vx_ff & vy;
               ALU_XOR:  alu_val = vx_ff ^ vy;
               ALU_ADD:  begin alu_val = sum9[7:0]; alu_f = {7'd0, sum9[8]}; end
               ALU_SUB:  begin alu_val = vx_ff - vy; alu_f = {7'd0, vx_ff >= vy}; end
               ALU_SHR:  begin alu_val = {1'b0, shift_src[7:1]}; alu_f = {7'd0, shift_src[0]}; end
               ALU_SUBN: begin alu_val = vy - vx_ff; alu_f = {7'd0, vy >= vx_ff}; end
               ALU_SHL:  begin alu_val = {shift_src[6:0], 1'b0}; alu_f = {7'd0, shift_src[7]}; end
               default:  alu_we = 1'b0;
            endcase
         end
         GRP_MISC: begin
            if (op_kk == MISC_GET_DELAY) begin
               alu_we = 1'b1;
               alu_val = delay_ff;
            end else if (op_kk == MISC_WAIT_KEY && latch_ff[4] && !keys_ff[latch_ff[3:0]]) begin
               alu_we = 1'b1;
               alu_val = {4'd0, latch_ff[3:0]};
            end
         end
         default: alu_we = 1'b0;
      endcase
   end

   // Conditional skips.
   always_comb begin
      unique case (op_grp)
         GRP_SEQ_K: skip = (vx_ff == op_kk);
         GRP_SNE_K: skip = (vx_ff != op_kk);
         GRP_SEQ_R: skip = (op_n == 4'd0) && (vx_ff == vy);
         GRP_SNE_R: skip = (op_n == 4'd0) && (vx_ff != vy);
         GRP_KEY: begin
            if (op_kk == KEY_DOWN) skip = keys_ff[vx_ff[3:0]];
            else if (op_kk == KEY_UP) skip = !keys_ff[vx_ff[3:0]];
            else skip = 1'b0;
         end
         default: skip = 1'b0;
      endcase
   end

   // Which sequence follows the execute step.
   always_comb begin
      kind = KIND_SIMPLE;
      if (op_ff == OP_RET && depth_ff != '0) begin
         kind = KIND_POP;
      end else if (op_grp == GRP_ALU) begin
         case (op_n) inside
            ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: kind = KIND_FLAG;
            ALU_OR, ALU_AND, ALU_XOR: kind = cfg_logic_clear_ff ? KIND_FLAG : KIND_SIMPLE;
            default: kind = KIND_SIMPLE;
         endcase
      end else if (op_grp == GRP_DRAW) begin
         kind = KIND_DRAW;
      end else if (op_grp == GRP_MISC) begin
         case (op_kk)
            MISC_BCD:   kind = KIND_BCD;
            MISC_STORE: kind = KIND_STORE;
            MISC_LOAD:  kind = KIND_LOAD;
            default:    kind = KIND_SIMPLE;
         endcase
      end
   end

   always_comb begin
      case (cmd.op)
         CMD_DRAW_RD: loop_done = !((cnt_ff < {1'b0, op_n}) && (draw_py < 6'd32));
         CMD_BCD: loop_done = (cnt_ff == 5'd2);
         CMD_STORE_WR, CMD_LOAD_WR: loop_done = (cnt_ff[3:0] == op_x);
         default: loop_done = 1'b0;
      endcase
   end

   // Memory, register file and stack ports.
   always_comb begin
      mem_we = 1'b0;
      mem_waddr = walk_addr;
      mem_wdata = 8'd0;
      mem_raddr = walk_addr;
      reg_we = 1'b0;
      reg_waddr = op_x;
      reg_wdata = alu_val;
      reg_raddr = op_x;
      stack_we = 1'b0;
      stack_addr = depth_ff[SW-1:0];
      case (cmd.op)
         CMD_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = boot_byte(clr_ff);
            reg_we = (clr_ff[11:4] == 8'd0);
            reg_waddr = clr_ff[3:0];
            reg_wdata = 8'd0;
         end
         CMD_WRITE: begin
            mem_we = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = wbyte_ff;
         end
         CMD_FETCH_HI: mem_raddr = pc_ff;
         CMD_FETCH_LO: mem_raddr = pc_ff + 12'd1;
         CMD_READ_Y: begin
            if (op_grp == GRP_JUMP_OFS && !cfg_jump_vx_ff) reg_raddr = 4'd0;
            else reg_raddr = op_y;
         end
         CMD_EXEC: begin
            reg_we = alu_we;
            if (op_ff == OP_RET) begin
               stack_addr = SW'(depth_ff - DW'(1));
            end
            stack_we = (op_grp == GRP_CALL) && (depth_ff < DW'(STACK_DEPTH));
         end
         CMD_WRITE_F: begin
            reg_we = 1'b1;
            reg_waddr = 4'hF;
            reg_wdata = f_ff;
         end
         CMD_BCD: begin
            mem_we = 1'b1;
            mem_wdata = bcd_digit;
         end
         CMD_STORE_RD: reg_raddr = cnt_ff[3:0];
         CMD_STORE_WR: begin
            mem_we = 1'b1;
            mem_wdata = reg_rd_ff;
         end
         CMD_LOAD_WR: begin
            reg_we = 1'b1;
            reg_waddr = cnt_ff[3:0];
            reg_wdata = mem_rd_ff;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      mem_rd_ff <= mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reg_we) regs_ff[reg_waddr] <= reg_wdata;
      reg_rd_ff <= regs_ff[reg_raddr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_ff[stack_addr] <= pc_ff;
      stack_rd_ff <= stack_ff[stack_addr];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_logic_clear_ff <= 1'b1;
         cfg_shift_vy_ff <= 1'b0;
         cfg_bulk_adv_ff <= 1'b0;
         cfg_jump_vx_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LOGIC_CLEAR: cfg_logic_clear_ff <= csr_write_data;
            CSR_SHIFT_VY:    cfg_shift_vy_ff <= csr_write_data;
            CSR_BULK_ADV:    cfg_bulk_adv_ff <= csr_write_data;
            default:         cfg_jump_vx_ff <= csr_write_data;
         endcase
      end
   end

   // Request capture and working registers.
   always_ff @(posedge clock) begin
      if (cmd.op == CMD_ACCEPT && req_valid) begin
         mode_ff <= req_mode;
         addr_ff <= req_address;
         wbyte_ff <= req_write_byte;
         keys_ff <= req_key_states;
         rnd_ff <= req_random_byte;
         row_ff <= 64'd0;
         redraw_ff <= 1'b0;
      end
      case (cmd.op)
         CMD_FETCH_LO: op_ff[15:8] <= mem_rd_ff;
         CMD_READ_X:   op_ff[7:0] <= mem_rd_ff;
         CMD_READ_Y:   vx_ff <= reg_rd_ff;
         CMD_EXEC: begin
            vy_ff <= reg_rd_ff;
            f_ff <= alu_f;
            cnt_ff <= 5'd0;
         end
         CMD_DRAW_WR: begin
            if ((fb_ff[draw_py[4:0]] & draw_mask) != 64'd0) f_ff <= 8'd1;
            cnt_ff <= cnt_ff + 5'd1;
         end
         CMD_BCD, CMD_STORE_WR, CMD_LOAD_WR: cnt_ff <= cnt_ff + 5'd1;
         CMD_TICK: redraw_ff <= draw_ff;
         CMD_ROW: begin
            if (addr_ff < 12'(ScreenHeight)) row_ff <= fb_ff[addr_ff[RowWidth-1:0]];
         end
         default: cnt_ff <= cnt_ff;
      endcase
   end

   // Architectural state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PROG_START;
         index_ff <= 12'd0;
         depth_ff <= '0;
         delay_ff <= 8'd0;
         sound_ff <= 8'd0;
         latch_ff <= 5'd0;
         halt_ff <= 1'b0;
         draw_ff <= 1'b1;
         clr_ff <= 12'd0;
         for (int r = 0; r < ScreenHeight; r++) fb_ff[r] <= '0;
      end else begin
         case (cmd.op)
            CMD_CLEAR: clr_ff <= clr_ff + 12'd1;
            CMD_TICK: begin
               if (delay_ff != 8'd0) delay_ff <= delay_ff - 8'd1;
               if (sound_ff != 8'd0) sound_ff <= sound_ff - 8'd1;
               draw_ff <= 1'b0;
            end
            CMD_READ_X: pc_ff <= pc_ff + 12'd2;
            CMD_EXEC: begin
               if (op_ff == OP_CLS) begin
                  for (int r = 0; r < ScreenHeight; r++) fb_ff[r] <= '0;
                  draw_ff <= 1'b1;
               end else if (op_ff == OP_RET) begin
                  if (depth_ff == '0) halt_ff <= 1'b1;
                  else depth_ff <= depth_ff - DW'(1);
               end else begin
                  unique case (op_grp)
                     GRP_JUMP: pc_ff <= op_nnn;
                     GRP_CALL: begin
                        if (depth_ff >= DW'(STACK_DEPTH)) begin
                           halt_ff <= 1'b1;
                        end else begin
                           depth_ff <= depth_ff + DW'(1);
                           pc_ff <= op_nnn;
                        end
                     end
                     GRP_SET_I: index_ff <= op_nnn;
                     GRP_JUMP_OFS: pc_ff <= op_nnn + {4'd0, cfg_jump_vx_ff ? vx_ff : vy};
                     GRP_DRAW: draw_ff <= 1'b1;
                     GRP_MISC: begin
                        case (op_kk)
                           MISC_WAIT_KEY: begin
                              if (!latch_ff[4]) begin
                                 if (any_key) latch_ff <= {1'b1, first_key};
                                 pc_ff <= pc_ff - 12'd2;
                              end else if (keys_ff[latch_ff[3:0]]) begin
                                 pc_ff <= pc_ff - 12'd2;
                              end else begin
                                 latch_ff <= 5'd0;
                              end
                           end
                           MISC_SET_DELAY: delay_ff <= vx_ff;
                           MISC_SET_SOUND: sound_ff <= vx_ff;
                           MISC_ADD_I: index_ff <= index_ff + {4'd0, vx_ff};
                           MISC_FONT: index_ff <= FONT_BASE + {6'd0, vx_ff[3:0], 2'd0}
                                                 + {8'd0, vx_ff[3:0]};
                           default: index_ff <= index_ff;
                        endcase
                     end
                     // Conditional skips step over the next instruction.
                     default: if (skip) pc_ff <= pc_ff + 12'd2;
                  endcase
               end
            end
            CMD_POP: pc_ff <= stack_rd_ff;
            CMD_DRAW_WR: fb_ff[draw_py[4:0]] <= fb_ff[draw_py[4:0]] ^ draw_mask;
            CMD_ADV_INDEX: begin
               if (cfg_bulk_adv_ff) index_ff <= index_ff + {8'd0, op_x} + 12'd1;
            end
            default: clr_ff <= clr_ff;
         endcase
      end
   end

   // Result register: refilled as soon as the previous beat has left.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == CMD_FINISH && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_FINISH && rsp_free) begin
         rsp_row_ff <= row_ff;
         rsp_pc_ff <= pc_ff;
         rsp_halt_ff <= halt_ff;
         rsp_sound_ff <= (sound_ff != 8'd0);
         rsp_redraw_ff <= redraw_ff;
      end
   end

   assign req_ready = (cmd.op == CMD_ACCEPT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_display_row = rsp_row_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_halted = rsp_halt_ff;
   assign rsp_sound_active = rsp_sound_ff;
   assign rsp_redraw_needed = rsp_redraw_ff;

   assign status.clear_done = (clr_ff == ADDR_LAST);
   assign status.req_valid = req_valid;
   assign status.mode = mode_ff;
   assign status.halted = halt_ff;
   assign status.kind = kind;
   assign status.loop_done = loop_done;
   assign status.rsp_free = rsp_free;

endmodule
